// File: rtl/core/lzbr_pkg.sv
// ----------------------------------------------------------------------------
// LZ back-reference decoder package
// Shared constants, codes and types for the decoder, its parser and its
// history window.
// ----------------------------------------------------------------------------
package lzbr_pkg;

   // History window geometry.
   localparam int unsigned WIN_DEPTH = 8192;
   localparam int unsigned PTR_W     = $clog2(WIN_DEPTH);
   localparam int unsigned PROD_W    = PTR_W + 1;

   // Run counters and displacements follow the 13-bit stream format.
   localparam int unsigned RUN_W = 13;

   // Stream format constants.
   localparam logic [7:0]       CONT_MASK = 8'he0;
   localparam logic [7:0]       CONT_CODE = 8'h60;
   localparam logic [7:0]       END_CODE  = 8'h00;
   localparam logic [RUN_W-1:0] FILL_BIAS = RUN_W'(4);

   typedef enum logic [2:0] {
      PH_CONTROL    = 3'd0,
      PH_DISP_LOW   = 3'd1,
      PH_LIT_COUNT  = 3'd2,
      PH_FILL_COUNT = 3'd3,
      PH_FILL_VALUE = 3'd4,
      PH_LITERALS   = 3'd5,
      PH_TRUNCATED  = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      KIND_DATA     = 3'd0,
      KIND_END      = 3'd1,
      KIND_BAD_DISP = 3'd2,
      KIND_TRUNC    = 3'd3,
      KIND_REFUSED  = 3'd4
   } kind_type;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   // Parser state; all zero is the start of a new stream.
   typedef struct packed {
      phase_type          phase;
      logic               after_copy;
      logic [7:0]         saved_control;
      logic [RUN_W-1:0]   literal_remaining;
      logic [RUN_W-1:0]   pending_count;
      logic               pending_is_copy;
      logic [7:0]         fill_value;
      logic [RUN_W-1:0]   copy_distance;
      logic [PROD_W-1:0]  produced_count;
      logic [PTR_W-1:0]   write_pointer;
   } parse_state_type;

   // Decoded events of one request.
   typedef struct packed {
      logic       adv_data;
      logic       emit;
      logic       parse;
      logic       enter_trunc;
      logic       term;
      logic       refuse;
      kind_type   term_kind;
   } event_type;

   // One request's command, handed from the parser to the output stage.
   typedef struct packed {
      logic              has_rsp;
      kind_type          kind;
      logic [7:0]        data;
      logic              is_copy;
      logic              rec;
      logic [PTR_W-1:0]  wr_addr;
      logic [PTR_W-1:0]  rd_addr;
   } cmd_type;

   // A displacement is good when it is nonzero and points at produced data.
   function automatic logic dist_ok(input logic [RUN_W-1:0] d,
                                    input logic [PROD_W-1:0] produced);
      dist_ok = (d != '0) && (PROD_W'(d) <= produced);
   endfunction

endpackage

// File: rtl/core/lzbr_window.sv
// ----------------------------------------------------------------------------
// LZ history window
// Synchronous single-write, single-read byte memory with a registered read.
// ----------------------------------------------------------------------------
module lzbr_window (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [lzbr_pkg::PTR_W-1:0] rd_addr,
   output logic [7:0]                rd_data,
   input  logic                      wr_en,
   input  logic [lzbr_pkg::PTR_W-1:0] wr_addr,
   input  logic [7:0]                wr_data
);

   logic [7:0] window_mem [lzbr_pkg::WIN_DEPTH];
   logic [7:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         window_mem[wr_addr] <= wr_data;
      end
   end

   // Read port; data is valid in the cycle after the address.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= window_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/lzbr_parser.sv
// ----------------------------------------------------------------------------
// LZ command parser
// Holds the stream state, decodes each request and produces the command
// that the output stage completes with window data.
// ----------------------------------------------------------------------------
module lzbr_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              operation,
   input  logic [7:0]        in_byte,
   input  logic              last_byte,
   output lzbr_pkg::cmd_type cmd
);

   lzbr_pkg::parse_state_type st_ff;
   lzbr_pkg::parse_state_type st_in;
   lzbr_pkg::event_type       ev;

   logic                          pend_nz;
   logic                          cont;
   logic [lzbr_pkg::RUN_W-1:0]    d_low;
   logic [lzbr_pkg::RUN_W-1:0]    lit_dec;
   logic [lzbr_pkg::PROD_W-1:0]   prod_inc;

   assign pend_nz = (st_ff.pending_count != '0);
   assign cont    = st_ff.after_copy && ((in_byte & lzbr_pkg::CONT_MASK) == lzbr_pkg::CONT_CODE);
   assign d_low   = {st_ff.saved_control[4:0], in_byte};
   assign lit_dec = (st_ff.literal_remaining != '0) ?
                    st_ff.literal_remaining - lzbr_pkg::RUN_W'(1) : st_ff.literal_remaining;

   // Produced count saturates at the window size.
   assign prod_inc = (st_ff.produced_count < lzbr_pkg::PROD_W'(lzbr_pkg::WIN_DEPTH)) ?
                     st_ff.produced_count + lzbr_pkg::PROD_W'(1) : st_ff.produced_count;

   // State register; advances only on an accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (accept) begin
         st_ff <= st_in;
      end
   end

   // Decode the request into events.
   always_comb begin
      logic pend_after;
      logic emit;
      logic early;
      lzbr_pkg::kind_type early_kind;
      pend_after = 1'b0;
      emit       = 1'b0;
      early      = 1'b0;
      early_kind = lzbr_pkg::KIND_DATA;
      ev         = '0;
      ev.term_kind = lzbr_pkg::KIND_DATA;
      if (operation == lzbr_pkg::OP_ADVANCE) begin
         if (pend_nz) begin
            ev.adv_data = 1'b1;
         end else if (st_ff.phase == lzbr_pkg::PH_TRUNCATED) begin
            ev.term      = 1'b1;
            ev.term_kind = lzbr_pkg::KIND_TRUNC;
         end
      end else if (pend_nz) begin
         ev.refuse = 1'b1;
      end else if (st_ff.phase == lzbr_pkg::PH_TRUNCATED) begin
         ev.term      = 1'b1;
         ev.term_kind = lzbr_pkg::KIND_TRUNC;
      end else begin
         unique case (st_ff.phase) inside
            lzbr_pkg::PH_DISP_LOW: begin
               if (!lzbr_pkg::dist_ok(d_low, st_ff.produced_count)) begin
                  early      = 1'b1;
                  early_kind = lzbr_pkg::KIND_BAD_DISP;
               end else begin
                  pend_after = 1'b1;
               end
            end
            lzbr_pkg::PH_LIT_COUNT, lzbr_pkg::PH_FILL_COUNT: begin
               pend_after = 1'b0;
            end
            lzbr_pkg::PH_FILL_VALUE: begin
               pend_after = 1'b1;
            end
            lzbr_pkg::PH_LITERALS: begin
               emit = 1'b1;
            end
            default: begin
               if (cont) begin
                  if (!lzbr_pkg::dist_ok(st_ff.copy_distance, st_ff.produced_count)) begin
                     early      = 1'b1;
                     early_kind = lzbr_pkg::KIND_BAD_DISP;
                  end else begin
                     pend_after = (in_byte[4:0] != '0);
                  end
               end else if (in_byte == lzbr_pkg::END_CODE) begin
                  early      = 1'b1;
                  early_kind = lzbr_pkg::KIND_END;
               end
            end
         endcase
         if (early) begin
            ev.term      = 1'b1;
            ev.term_kind = early_kind;
         end else if (last_byte && !emit && !pend_after) begin
            ev.term      = 1'b1;
            ev.term_kind = lzbr_pkg::KIND_TRUNC;
         end else begin
            ev.parse       = 1'b1;
            ev.emit        = emit;
            ev.enter_trunc = last_byte;
         end
      end
   end

   // Next state.
   always_comb begin
      st_in = st_ff;
      if (ev.term) begin
         st_in = '0;
      end else if (ev.adv_data) begin
         st_in.pending_count  = st_ff.pending_count - lzbr_pkg::RUN_W'(1);
         st_in.write_pointer  = st_ff.write_pointer + lzbr_pkg::PTR_W'(1);
         st_in.produced_count = prod_inc;
      end else if (ev.parse) begin
         unique case (st_ff.phase)
            lzbr_pkg::PH_DISP_LOW: begin
               st_in.copy_distance   = d_low;
               st_in.pending_count   = lzbr_pkg::RUN_W'({1'b1, st_ff.saved_control[6:5]});
               st_in.pending_is_copy = 1'b1;
               st_in.after_copy      = 1'b1;
               st_in.phase           = lzbr_pkg::PH_CONTROL;
            end
            lzbr_pkg::PH_LIT_COUNT: begin
               st_in.literal_remaining = d_low;
               st_in.phase = (d_low != '0) ? lzbr_pkg::PH_LITERALS : lzbr_pkg::PH_CONTROL;
            end
            lzbr_pkg::PH_FILL_COUNT: begin
               st_in.literal_remaining =
                  lzbr_pkg::RUN_W'({st_ff.saved_control[3:0], in_byte}) + lzbr_pkg::FILL_BIAS;
               st_in.phase = lzbr_pkg::PH_FILL_VALUE;
            end
            lzbr_pkg::PH_FILL_VALUE: begin
               st_in.fill_value        = in_byte;
               st_in.pending_count     = st_ff.literal_remaining;
               st_in.literal_remaining = '0;
               st_in.pending_is_copy   = 1'b0;
               st_in.phase             = lzbr_pkg::PH_CONTROL;
            end
            lzbr_pkg::PH_LITERALS: begin
               st_in.write_pointer     = st_ff.write_pointer + lzbr_pkg::PTR_W'(1);
               st_in.produced_count    = prod_inc;
               st_in.literal_remaining = lit_dec;
               if (lit_dec == '0) begin
                  st_in.phase = lzbr_pkg::PH_CONTROL;
               end
            end
            default: begin
               st_in.phase = lzbr_pkg::PH_CONTROL;
               if (cont) begin
                  st_in.pending_count   = lzbr_pkg::RUN_W'(in_byte[4:0]);
                  st_in.pending_is_copy = 1'b1;
               end else begin
                  st_in.after_copy    = 1'b0;
                  st_in.saved_control = in_byte;
                  if (in_byte[7]) begin
                     st_in.phase = lzbr_pkg::PH_DISP_LOW;
                  end else if (in_byte[6]) begin
                     if (in_byte[4]) begin
                        st_in.phase = lzbr_pkg::PH_FILL_COUNT;
                     end else begin
                        st_in.literal_remaining =
                           lzbr_pkg::RUN_W'(in_byte[3:0]) + lzbr_pkg::FILL_BIAS;
                        st_in.phase = lzbr_pkg::PH_FILL_VALUE;
                     end
                  end else if (in_byte[5]) begin
                     st_in.phase = lzbr_pkg::PH_LIT_COUNT;
                  end else begin
                     st_in.literal_remaining = lzbr_pkg::RUN_W'(in_byte[4:0]);
                     st_in.phase = (in_byte[4:0] != '0) ?
                                   lzbr_pkg::PH_LITERALS : lzbr_pkg::PH_CONTROL;
                  end
               end
            end
         endcase
         // The final source byte left output behind: finish it, then report.
         if (ev.enter_trunc) begin
            st_in.phase             = lzbr_pkg::PH_TRUNCATED;
            st_in.literal_remaining = '0;
            st_in.after_copy        = 1'b0;
         end
      end
   end

   // Command for the output stage.
   always_comb begin
      cmd         = '0;
      cmd.kind    = lzbr_pkg::KIND_DATA;
      cmd.has_rsp = ev.adv_data | ev.emit | ev.term | ev.refuse;
      if (ev.term) begin
         cmd.kind = ev.term_kind;
      end else if (ev.refuse) begin
         cmd.kind = lzbr_pkg::KIND_REFUSED;
      end
      if (ev.adv_data) begin
         cmd.data = st_ff.fill_value;
      end else if (ev.emit) begin
         cmd.data = in_byte;
      end
      cmd.is_copy = ev.adv_data & st_ff.pending_is_copy;
      cmd.rec     = ev.adv_data | ev.emit;
      cmd.wr_addr = st_ff.write_pointer;
      cmd.rd_addr = st_ff.write_pointer - lzbr_pkg::PTR_W'(st_ff.copy_distance);
   end

endmodule

// File: rtl/core/lz_back_reference_decoder.sv
// ----------------------------------------------------------------------------
// LZ back-reference decoder
// Streaming decoder for literal runs, fill runs and back-references with an
// 8 KiB history window.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid/req_ready    req_operation, req_in_byte,
//                                               req_last_byte
//   rsp_      out        rsp_valid/rsp_ready    rsp_out_byte, rsp_kind
//
// One request is accepted per cycle while the output is not stalled; a result
// passes through one window-read stage and the output register.
// Copies read the window when accepted and write it when the window stage
// moves on; a copy of the byte still being written uses a forwarding register.
// A stalled output holds the window stage, which then stops new requests.
// Reset clears the parser and handshake state at once; there is no clearing
// pass, since a window entry is only read after it was written.
// ----------------------------------------------------------------------------
module lz_back_reference_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_operation,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_kind
);

   lzbr_pkg::cmd_type cmd;
   lzbr_pkg::cmd_type s2_cmd_ff;
   logic              s2_valid_ff;
   logic              s2_valid_in;
   logic              s2_fwd_ff;
   logic [7:0]        fwd_data_ff;
   logic              s2_move;
   logic              s2_wr;
   logic [7:0]        s2_value;
   logic [7:0]        rd_data;
   logic              accept;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic              out_load;
   logic [7:0]        out_byte_ff;
   lzbr_pkg::kind_type out_kind_ff;

   // Handshake and stage movement.
   assign s2_move   = s2_valid_ff && (!s2_cmd_ff.has_rsp || !out_valid_ff || rsp_ready);
   assign req_ready = !s2_valid_ff || s2_move;
   assign accept    = req_valid && req_ready;
   assign s2_wr     = s2_move && s2_cmd_ff.rec;

   lzbr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (req_operation),
      .in_byte   (req_in_byte),
      .last_byte (req_last_byte),
      .cmd       (cmd)
   );

   lzbr_window u_window (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_data),
      .wr_en   (s2_wr),
      .wr_addr (s2_cmd_ff.wr_addr),
      .wr_data (s2_value)
   );

   // Byte of the window stage: window data for copies, else the carried byte.
   always_comb begin
      if (!s2_cmd_ff.is_copy) begin
         s2_value = s2_cmd_ff.data;
      end else if (s2_fwd_ff) begin
         s2_value = fwd_data_ff;
      end else begin
         s2_value = rd_data;
      end
   end

   // Window stage valid.
   always_comb begin
      if (accept) begin
         s2_valid_in = 1'b1;
      end else if (s2_move) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Window stage payload, with forwarding of a write to the same entry.
   always_ff @(posedge clock) begin
      if (accept) begin
         s2_cmd_ff   <= cmd;
         s2_fwd_ff   <= s2_wr && (cmd.rd_addr == s2_cmd_ff.wr_addr);
         fwd_data_ff <= s2_value;
      end
   end

   // Output register.
   assign out_load     = s2_move && s2_cmd_ff.has_rsp;
   assign out_valid_in = out_load || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_byte_ff <= s2_value;
         out_kind_ff <= s2_cmd_ff.kind;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_kind     = out_kind_ff;

endmodule
